/* hdl/gwf_pkg.sv */
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared types, widths and constants of the Gaussian window filter.
// ----------------------------------------------------------------------------
package gwf_pkg;

	// Default configuration
	localparam int WINDOW_DEF      = 6;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Fixed field and datapath widths (sized for windows up to 8)
	localparam int SAMPLE_W  = 24;
	localparam int FRAC_W    = 17;
	localparam int FALLOFF_W = 16;
	localparam int WEIGHT_W  = 18;
	localparam int EXP_W     = 19;
	localparam int U_W       = 30;
	localparam int TERM_W    = 31;
	localparam int M_W       = 20;
	localparam int MM_W      = 2 * M_W;
	localparam int TP_W      = FALLOFF_W + M_W;
	localparam int T_W       = 56;
	localparam int ACC_W     = 56;
	localparam int TOT_W     = 30;
	localparam int NUM_W     = ACC_W + 2;
	localparam int REM_W     = TOT_W + 1;
	localparam int K_W       = 4;

	localparam logic [FALLOFF_W-1:0] FALLOFF_RST  = 16'd655;
	localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX   = '1;
	localparam logic [K_W-1:0]       SERIES_LAST  = 4'd14;
	localparam logic [SAMPLE_W-1:0]  RES_POS_MAX  = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0]  RES_NEG_MIN  = 24'h800000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [FRAC_W-1:0]          frac_x;
		logic [FRAC_W-1:0]          frac_y;
	} gwf_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       zero_weight;
	} gwf_result_t;

	// Queue entry: the item tagged with its place in the window
	typedef struct packed {
		gwf_item_t item;
		logic      first;
		logic      last;
	} gwf_entry_t;

	typedef struct packed {
		logic           start;
		logic           over;
		logic [U_W-1:0] u;
	} gwf_exp_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [EXP_W-1:0] value;
	} gwf_exp_rsp_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_MUL,
		EX_DIV,
		EX_CORR,
		EX_SQR,
		EX_FIN,
		EX_DONE
	} gwf_exp_state_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_OFS,
		BK_OFS_W,
		BK_SQ,
		BK_TLO,
		BK_THI,
		BK_EXP,
		BK_EXP_W,
		BK_MAC1,
		BK_MAC2,
		BK_DIV_SET,
		BK_DIV,
		BK_FIN,
		BK_OUT
	} gwf_back_state_t;

	// floor(2^32 / k) for the series divisors
	function automatic logic [32:0] recip(input logic [K_W-1:0] k);
		logic [32:0] r;
		unique case (k)
			4'd1:    r = 33'd4294967296;
			4'd2:    r = 33'd2147483648;
			4'd3:    r = 33'd1431655765;
			4'd4:    r = 33'd1073741824;
			4'd5:    r = 33'd858993459;
			4'd6:    r = 33'd715827882;
			4'd7:    r = 33'd613566756;
			4'd8:    r = 33'd536870912;
			4'd9:    r = 33'd477218588;
			4'd10:   r = 33'd429496729;
			4'd11:   r = 33'd390451572;
			4'd12:   r = 33'd357913941;
			4'd13:   r = 33'd330382099;
			4'd14:   r = 33'd306783378;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* hdl/gwf_front.sv */
// ----------------------------------------------------------------------------
// gwf_front
// Accepts samples, tracks the position in the window and tags each request
// as first or last of its window before queueing it.
// ----------------------------------------------------------------------------
module gwf_front #(
	parameter int WINDOW = gwf_pkg::WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  gwf_pkg::gwf_item_t  item,
	input  logic                q_full,
	output logic                q_push,
	output gwf_pkg::gwf_entry_t q_entry
);
	import gwf_pkg::*;

	localparam int WW    = WINDOW * WINDOW;
	localparam int IDX_W = $clog2(WW);

	logic [IDX_W-1:0] idx_q;
	logic             at_last;

	assign item_ready = !q_full;
	assign q_push     = item_valid && !q_full;
	assign at_last    = (idx_q == IDX_W'(WW - 1));

	// Tag the request
	assign q_entry.item  = item;
	assign q_entry.first = (idx_q == '0);
	assign q_entry.last  = at_last;

	// Advance the window position, wrap after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (q_push) begin
			idx_q <= at_last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

/* hdl/gwf_queue.sv */
// ----------------------------------------------------------------------------
// gwf_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module gwf_queue #(
	parameter int DEPTH = gwf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gwf_pkg::gwf_entry_t wr_entry,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output gwf_pkg::gwf_entry_t rd_entry
);
	import gwf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gwf_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	// Store the request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/gwf_exp.sv */
// ----------------------------------------------------------------------------
// gwf_exp
// Iterative exp(-t): fifteen-term alternating series on t/16, then four
// squarings. One multiply per cycle; divide by k through a reciprocal.
// ----------------------------------------------------------------------------
module gwf_exp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gwf_pkg::gwf_exp_req_t req,
	output gwf_pkg::gwf_exp_rsp_t rsp
);
	import gwf_pkg::*;

	gwf_exp_state_t state_q, state_d;

	logic [U_W-1:0]       u_q;
	logic [TERM_W-1:0]    term_q;
	logic signed [31:0]   s_q;
	logic [K_W-1:0]       k_q;
	logic [1:0]           n_q;
	logic [TERM_W-1:0]    tp_q;
	logic [TERM_W-1:0]    q0_q;
	logic [TERM_W-1:0]    r_q;
	logic [EXP_W-1:0]     value_q;

	logic [60:0]          mul_tu;
	logic [63:0]          mul_rc;
	logic [34:0]          mul_qk;
	logic [TERM_W-1:0]    rem;
	logic [TERM_W-1:0]    q_fix;
	logic signed [31:0]   s_next;
	logic [61:0]          sq;

	// Series datapath
	assign mul_tu = 61'(term_q) * 61'(u_q);
	assign mul_rc = 64'(tp_q) * 64'(recip(k_q));
	assign mul_qk = 35'(q0_q) * 35'(k_q);
	assign rem    = tp_q - mul_qk[TERM_W-1:0];
	assign q_fix  = q0_q + TERM_W'(rem >= TERM_W'(k_q));
	assign s_next = k_q[0] ? s_q - $signed({1'b0, q_fix}) : s_q + $signed({1'b0, q_fix});
	assign sq     = 62'(r_q) * 62'(r_q) + (62'd1 << 29);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_IDLE: begin
				if (req.start) state_d = req.over ? EX_DONE : EX_MUL;
			end
			EX_MUL:  state_d = EX_DIV;
			EX_DIV:  state_d = EX_CORR;
			EX_CORR: state_d = (k_q == SERIES_LAST) ? EX_SQR : EX_MUL;
			EX_SQR:  state_d = (n_q == 2'd3) ? EX_FIN : EX_SQR;
			EX_FIN:  state_d = EX_DONE;
			EX_DONE: state_d = EX_IDLE;
			default: state_d = EX_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		rsp.busy  = (state_q != EX_IDLE);
		rsp.done  = (state_q == EX_DONE);
		rsp.value = value_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == EX_IDLE && req.start) begin
				k_q <= 4'd1;
				n_q <= '0;
			end else if (state_q == EX_CORR) begin
				k_q <= k_q + 1'b1;
			end else if (state_q == EX_SQR) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	// Series and squaring datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			EX_IDLE: begin
				if (req.start) begin
					u_q     <= req.u;
					term_q  <= TERM_W'(1) << 30;
					s_q     <= 32'sd1 <<< 30;
					value_q <= '0;
				end
			end
			EX_MUL:  tp_q <= mul_tu[60:30];
			EX_DIV:  q0_q <= mul_rc[62:32];
			EX_CORR: begin
				term_q <= q_fix;
				s_q    <= s_next;
				if (k_q == SERIES_LAST) begin
					r_q <= s_next[31] ? '0 : s_next[TERM_W-1:0];
				end
			end
			EX_SQR:  r_q <= sq[60:30];
			EX_FIN:  value_q <= EXP_W'((r_q + TERM_W'(2048)) >> 12);
			default: begin
			end
		endcase
	end

endmodule

/* hdl/gwf_back.sv */
// ----------------------------------------------------------------------------
// gwf_back
// Builds the window weights on the first sample, multiplies and accumulates
// every sample, and divides out the weighted mean after the last one.
// ----------------------------------------------------------------------------
module gwf_back #(
	parameter int WINDOW = gwf_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [gwf_pkg::FALLOFF_W-1:0]     falloff,
	input  logic                              q_empty,
	input  gwf_pkg::gwf_entry_t               q_entry,
	output logic                              q_pop,
	output gwf_pkg::gwf_exp_req_t             exp_req,
	input  gwf_pkg::gwf_exp_rsp_t             exp_rsp,
	output logic                              result_valid,
	input  logic                              result_ready,
	output gwf_pkg::gwf_result_t              result
);
	import gwf_pkg::*;

	localparam int WW   = WINDOW * WINDOW;
	localparam int IW   = $clog2(WINDOW);
	localparam int OFS  = WINDOW * 32768 - 65536;
	localparam int CT_W = $clog2(NUM_W);

	gwf_back_state_t state_q, state_d;

	gwf_entry_t             ent_q;
	logic [EXP_W-1:0]       eoff_q;
	logic [IW-1:0]          i_q;
	logic                   sel_col_q;
	logic [MM_W-1:0]        mm_q;
	logic [TP_W-1:0]        t_lo_q;
	logic [T_W-1:0]         t_q;
	logic [WEIGHT_W-1:0]    row_w_q [WINDOW];
	logic [WEIGHT_W-1:0]    col_w_q [WINDOW];
	logic [IW-1:0]          row_q;
	logic [IW-1:0]          col_q;
	logic [WEIGHT_W-1:0]    w2_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [TOT_W-1:0]       tot_q;
	logic                   neg_q;
	logic [NUM_W-1:0]       num_q;
	logic [REM_W-1:0]       den_q;
	logic [REM_W-1:0]       rem_q;
	logic [NUM_W-1:0]       quo_q;
	logic [CT_W-1:0]        cnt_q;
	gwf_result_t            mean_q;
	gwf_result_t            res_q;
	logic                   result_valid_q;

	logic                   out_load;
	logic                   i_last;
	logic [FRAC_W-1:0]      frac;
	logic [21:0]            d;
	logic [M_W-1:0]         m;
	logic [21:0]            ofs_prod;
	logic [EXP_W-1:0]       e_diff;
	logic [WEIGHT_W-1:0]    w_new;
	logic [35:0]            w2_prod;
	logic signed [42:0]     mac_prod;
	logic [ACC_W-1:0]       mag;
	logic [REM_W:0]         rem_sh;
	logic                   rem_ge;

	assign i_last = (i_q == IW'(WINDOW - 1));

	// Distance from the offset to tap i
	assign frac = sel_col_q ? ent_q.item.frac_y : ent_q.item.frac_x;
	assign d    = 22'(frac) + 22'(OFS) - (22'(i_q) << 16);
	assign m    = d[21] ? M_W'(-d) : M_W'(d);

	assign ofs_prod = 22'(falloff) * 22'(WW);

	// Weight: drop the tail offset, clamp at zero and at full scale
	assign e_diff = exp_rsp.value - eoff_q;
	always_comb begin
		if (exp_rsp.value <= eoff_q) begin
			w_new = '0;
		end else if (e_diff > EXP_W'(WEIGHT_MAX)) begin
			w_new = WEIGHT_MAX;
		end else begin
			w_new = e_diff[WEIGHT_W-1:0];
		end
	end

	assign w2_prod  = 36'(row_w_q[row_q]) * 36'(col_w_q[col_q]);
	assign mac_prod = 43'(ent_q.item.sample) * 43'($signed({1'b0, w2_q}));
	assign mag      = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	// One quotient bit per cycle
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign rem_ge = (rem_sh >= (REM_W + 1)'(den_q));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) state_d = q_entry.first ? BK_OFS : BK_MAC1;
			end
			BK_OFS:   state_d = BK_OFS_W;
			BK_OFS_W: if (exp_rsp.done) state_d = BK_SQ;
			BK_SQ:    state_d = BK_TLO;
			BK_TLO:   state_d = BK_THI;
			BK_THI:   state_d = BK_EXP;
			BK_EXP:   state_d = BK_EXP_W;
			BK_EXP_W: begin
				if (exp_rsp.done) state_d = (i_last && sel_col_q) ? BK_MAC1 : BK_SQ;
			end
			BK_MAC1:  state_d = BK_MAC2;
			BK_MAC2:  state_d = ent_q.last ? BK_DIV_SET : BK_IDLE;
			BK_DIV_SET: state_d = (tot_q == '0) ? BK_OUT : BK_DIV;
			BK_DIV:   if (cnt_q == CT_W'(NUM_W - 1)) state_d = BK_FIN;
			BK_FIN:   state_d = BK_OUT;
			BK_OUT:   if (out_load) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		q_pop         = (state_q == BK_IDLE) && !q_empty;
		out_load      = (state_q == BK_OUT) && (!result_valid_q || result_ready);
		exp_req.start = (state_q == BK_OFS) || (state_q == BK_EXP);
		exp_req.over  = (state_q == BK_EXP) && (|t_q[T_W-1:52]);
		exp_req.u     = (state_q == BK_OFS) ? {ofs_prod, 8'b0} : t_q[51:22];
	end

	assign result_valid = result_valid_q;
	assign result       = res_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_IDLE;
			result_valid_q <= 1'b0;
			i_q            <= '0;
			sel_col_q      <= 1'b0;
			row_q          <= '0;
			col_q          <= '0;
			cnt_q          <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (q_pop && q_entry.first) begin
				i_q       <= '0;
				sel_col_q <= 1'b0;
				row_q     <= '0;
				col_q     <= '0;
			end
			if (state_q == BK_EXP_W && exp_rsp.done) begin
				i_q <= i_last ? '0 : i_q + 1'b1;
				if (i_last) sel_col_q <= 1'b1;
			end
			if (state_q == BK_MAC2) begin
				col_q <= (col_q == IW'(WINDOW - 1)) ? '0 : col_q + 1'b1;
				if (col_q == IW'(WINDOW - 1)) row_q <= row_q + 1'b1;
			end
			if (state_q == BK_DIV_SET) begin
				cnt_q <= '0;
			end else if (state_q == BK_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) ent_q <= q_entry;
		if (state_q == BK_OFS_W && exp_rsp.done) eoff_q <= exp_rsp.value;
		if (state_q == BK_SQ) mm_q <= MM_W'(m) * MM_W'(m);
		if (state_q == BK_TLO) t_lo_q <= TP_W'(falloff) * TP_W'(mm_q[M_W-1:0]);
		if (state_q == BK_THI) begin
			t_q <= ((T_W'(falloff) * T_W'(mm_q[MM_W-1:M_W])) << M_W) + T_W'(t_lo_q);
		end
		if (state_q == BK_EXP_W && exp_rsp.done) begin
			if (sel_col_q) col_w_q[i_q] <= w_new;
			else           row_w_q[i_q] <= w_new;
		end
		if (state_q == BK_MAC1) w2_q <= w2_prod[35:18];
		if (state_q == BK_MAC2) begin
			acc_q <= (ent_q.first ? '0 : acc_q) + ACC_W'(mac_prod);
			tot_q <= (ent_q.first ? '0 : tot_q) + TOT_W'(w2_q);
		end
		if (state_q == BK_DIV_SET) begin
			neg_q  <= acc_q[ACC_W-1];
			num_q  <= NUM_W'({mag, 1'b0}) + NUM_W'(tot_q);
			den_q  <= {tot_q, 1'b0};
			rem_q  <= '0;
			quo_q  <= '0;
			mean_q <= '{filtered: '0, zero_weight: 1'b1};
		end
		if (state_q == BK_DIV) begin
			rem_q <= rem_ge ? REM_W'(rem_sh - (REM_W + 1)'(den_q)) : REM_W'(rem_sh);
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_W-2:0], rem_ge};
		end
		// Round has been folded in; saturate to the output range
		if (state_q == BK_FIN) begin
			mean_q.zero_weight <= 1'b0;
			if (neg_q) begin
				mean_q.filtered <= (quo_q > NUM_W'(8388608)) ? RES_NEG_MIN
				                                             : (~quo_q[SAMPLE_W-1:0] + 1'b1);
			end else begin
				mean_q.filtered <= (quo_q > NUM_W'(8388607)) ? RES_POS_MAX
				                                             : quo_q[SAMPLE_W-1:0];
			end
		end
		// Hand the mean to the output register once it is free
		if (out_load) res_q <= mean_q;
	end

endmodule

/* hdl/gaussian_window_filter_core.sv */
// ----------------------------------------------------------------------------
// gaussian_window_filter_core
// Separable Gaussian weighted mean over a WINDOW x WINDOW patch of samples.
// ----------------------------------------------------------------------------
// A first sample of a window takes 2*WINDOW+1 runs of the shared exp unit, each
// a series loop of 14 multiply, divide and correct steps, plus square and scale
// steps per weight; other samples just multiply-accumulate in the back end.
// The back end takes one queued request at a time; the last sample of a window
// adds a bit-serial divide. Queue holds QUEUE_DEPTH requests (4 by default).
// Reset: arst_n clears all control state at once; falloff returns to 655.
// ----------------------------------------------------------------------------
module gaussian_window_filter_core #(
	parameter int WINDOW      = gwf_pkg::WINDOW_DEF,
	parameter int QUEUE_DEPTH = gwf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gwf_pkg::FALLOFF_W-1:0] cfg_wdata,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  gwf_pkg::gwf_item_t            item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output gwf_pkg::gwf_result_t          result
);
	import gwf_pkg::*;

	logic [FALLOFF_W-1:0] falloff_q;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;
	gwf_entry_t           q_wr_entry;
	gwf_entry_t           q_rd_entry;
	gwf_exp_req_t         exp_req;
	gwf_exp_rsp_t         exp_rsp;

	// Hold the falloff coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			falloff_q <= FALLOFF_RST;
		end else if (cfg_we) begin
			falloff_q <= cfg_wdata;
		end
	end

	gwf_front #(.WINDOW(WINDOW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_wr_entry)
	);

	gwf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.rd_entry (q_rd_entry)
	);

	gwf_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (exp_req),
		.rsp    (exp_rsp)
	);

	gwf_back #(.WINDOW(WINDOW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.falloff      (falloff_q),
		.q_empty      (q_empty),
		.q_entry      (q_rd_entry),
		.q_pop        (q_pop),
		.exp_req      (exp_req),
		.exp_rsp      (exp_rsp),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

	a_exp_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		exp_req.start |-> !exp_rsp.busy)
		else $error("exp started while busy");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.zero_weight) |-> (result.filtered == '0))
		else $error("zero weight with non-zero result");
`endif

endmodule
